[sv/ray_sphere_hit_point_assert.svh]
// Assertion macros for the ray / sphere hit point pipeline.
// Used by ray_sphere_hit_point.sv; expects clk and rst_n in scope.
`ifndef RAY_SPHERE_HIT_POINT_ASSERT_SVH
`define RAY_SPHERE_HIT_POINT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RSHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rshp check failed");

// Next-cycle implication, checked outside reset
`define RSHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rshp check failed");

`endif

[sv/rshp_pkg.sv]
// Types, widths and helper functions for the ray / sphere hit point pipeline.
// No dependencies.
package rshp_pkg;

  localparam int SQ_STEPS = 31;
  localparam int SQ_PER   = 2;
  localparam int SQ_STG   = (SQ_STEPS + SQ_PER - 1) / SQ_PER;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               origin_inside;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_item_t;

  // Ray data and the inside flag carried along the pipe
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][15:0] dir;
    logic             org_in;
  } ctx_t;

  // Square root working state
  typedef struct packed {
    logic [61:0]        rad;
    logic [32:0]        rem;
    logic [30:0]        root;
    logic               miss;
    logic signed [37:0] xt;
  } sq_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out
  function automatic sq_t sq_step(sq_t a);
    sq_t b;
    logic [34:0] acc;
    logic [34:0] trial;
    logic [34:0] dif;
    b = a;
    acc = {a.rem, a.rad[61:60]};
    trial = {2'b00, a.root, 2'b01};
    dif = acc - trial;
    b.rad = {a.rad[59:0], 2'b00};
    if (acc >= trial) begin
      b.rem = dif[32:0];
      b.root = {a.root[29:0], 1'b1};
    end else begin
      b.rem = acc[32:0];
      b.root = {a.root[29:0], 1'b0};
    end
    return b;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -43'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/ray_sphere_hit_point.sv]
// Ray / sphere first hit point, fixed point, fully pipelined.
// Pipeline: 7 front stages, 16 square root stages of two root bits each (the
// last one does only one root bit), 3 back stages.
// Throughput: one item per cycle; the whole pipe holds while the output waits.
// Reset (rst_n, synchronous, active low) clears all valid bits; data is not reset.
// Depends on rshp_pkg and ray_sphere_hit_point_assert.svh.
`include "ray_sphere_hit_point_assert.svh"

module ray_sphere_hit_point
  import rshp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: difference center - origin
  logic              v1_r;
  logic signed [32:0] s1_d_r [3];
  logic [30:0]       s1_rad_r;
  ctx_t              s1_ctx_r;
  logic signed [31:0] cin [3];
  logic signed [31:0] oin [3];

  assign cin[0] = in_data.center_x;
  assign cin[1] = in_data.center_y;
  assign cin[2] = in_data.center_z;
  assign oin[0] = in_data.origin_x;
  assign oin[1] = in_data.origin_y;
  assign oin[2] = in_data.origin_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i] <= {cin[i][31], cin[i]} - {oin[i][31], oin[i]};
      end
      s1_rad_r <= in_data.sphere_radius;
      s1_ctx_r.org <= {in_data.origin_z, in_data.origin_y, in_data.origin_x};
      s1_ctx_r.dir <= {in_data.dir_z, in_data.dir_y, in_data.dir_x};
      s1_ctx_r.org_in <= 1'b0;
    end
  end

  // Stage 2: squares of d, d times dir, r squared
  logic              v2_r;
  logic [61:0]       s2_dsq_r [3];
  logic signed [48:0] s2_dp_r [3];
  logic [61:0]       s2_r2_r;
  logic              s2_far_r;
  logic signed [32:0] s2_d_r [3];
  ctx_t              s2_ctx_r;
  logic [32:0]       d_abs [3];
  logic [2:0]        d_far;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_abs[i] = s1_d_r[i][32] ? 33'(-s1_d_r[i]) : s1_d_r[i];
      d_far[i] = d_abs[i][32] | d_abs[i][31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_dsq_r[i] <= d_abs[i][30:0] * d_abs[i][30:0];
        s2_dp_r[i] <= s1_d_r[i] * $signed(s1_ctx_r.dir[i]);
      end
      s2_r2_r <= s1_rad_r * s1_rad_r;
      s2_far_r <= |d_far;
      s2_d_r <= s1_d_r;
      s2_ctx_r <= s1_ctx_r;
    end
  end

  // Stage 3: inside test and closest approach x_t
  logic              v3_r;
  logic signed [37:0] s3_xt_r;
  logic [61:0]       s3_r2_r;
  logic signed [32:0] s3_d_r [3];
  ctx_t              s3_ctx_r;
  logic [63:0]       dsum;
  logic signed [51:0] dotr;

  assign dsum = 64'(s2_dsq_r[0]) + 64'(s2_dsq_r[1]) + 64'(s2_dsq_r[2]);
  assign dotr = 52'(s2_dp_r[0]) + 52'(s2_dp_r[1]) + 52'(s2_dp_r[2]) + 52'sd8192;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_xt_r <= dotr[51:14];
      s3_r2_r <= s2_r2_r;
      s3_d_r <= s2_d_r;
      s3_ctx_r.org <= s2_ctx_r.org;
      s3_ctx_r.dir <= s2_ctx_r.dir;
      s3_ctx_r.org_in <= !s2_far_r && (dsum < {2'b00, s2_r2_r});
    end
  end

  // Stage 4: dir times x_t
  logic              v4_r;
  logic signed [53:0] s4_pe_r [3];
  logic signed [37:0] s4_xt_r;
  logic [61:0]       s4_r2_r;
  logic signed [32:0] s4_d_r [3];
  ctx_t              s4_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_pe_r[i] <= $signed(s3_ctx_r.dir[i]) * s3_xt_r;
      end
      s4_xt_r <= s3_xt_r;
      s4_r2_r <= s3_r2_r;
      s4_d_r <= s3_d_r;
      s4_ctx_r <= s3_ctx_r;
    end
  end

  // Stage 5: offset e from the closest point to the center
  logic              v5_r;
  logic [30:0]       s5_ea_r [3];
  logic              s5_far_r;
  logic signed [37:0] s5_xt_r;
  logic [61:0]       s5_r2_r;
  ctx_t              s5_ctx_r;
  logic signed [53:0] per [3];
  logic signed [41:0] ev [3];
  logic [41:0]       e_abs [3];
  logic [2:0]        e_far;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      per[i] = s4_pe_r[i] + 54'sd8192;
      ev[i] = 42'($signed(per[i][53:14])) - 42'(s4_d_r[i]);
      e_abs[i] = ev[i][41] ? 42'(-ev[i]) : ev[i];
      e_far[i] = |e_abs[i][41:31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_ea_r[i] <= e_abs[i][30:0];
      end
      s5_far_r <= |e_far;
      s5_xt_r <= s4_xt_r;
      s5_r2_r <= s4_r2_r;
      s5_ctx_r <= s4_ctx_r;
    end
  end

  // Stage 6: squares of e
  logic              v6_r;
  logic [61:0]       s6_esq_r [3];
  logic              s6_far_r;
  logic signed [37:0] s6_xt_r;
  logic [61:0]       s6_r2_r;
  ctx_t              s6_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s6_esq_r[i] <= s5_ea_r[i] * s5_ea_r[i];
      end
      s6_far_r <= s5_far_r;
      s6_xt_r <= s5_xt_r;
      s6_r2_r <= s5_r2_r;
      s6_ctx_r <= s5_ctx_r;
    end
  end

  // Stage 7: miss test and radicand r^2 - h^2
  logic        v7_r;
  sq_t         s7_sq_r;
  ctx_t        s7_ctx_r;
  logic [63:0] esum;
  logic [61:0] rdiff;

  assign esum = 64'(s6_esq_r[0]) + 64'(s6_esq_r[1]) + 64'(s6_esq_r[2]);
  assign rdiff = s6_r2_r - esum[61:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_sq_r.rad <= rdiff;
      s7_sq_r.rem <= '0;
      s7_sq_r.root <= '0;
      s7_sq_r.miss <= s6_far_r || (esum > {2'b00, s6_r2_r});
      s7_sq_r.xt <= s6_xt_r;
      s7_ctx_r <= s6_ctx_r;
    end
  end

  // Square root pipeline: two root bits per stage, one in the last stage
  logic [SQ_STG-1:0] sqv_r;
  sq_t               sq_r [SQ_STG];
  ctx_t              sqc_r [SQ_STG];

  genvar j;
  for (j = 0; j < SQ_STG; j++) begin : g_sq
    sq_t  src;
    sq_t  nx;
    ctx_t csrc;
    logic vsrc;

    if (j == 0) begin : g_first
      assign src = s7_sq_r;
      assign csrc = s7_ctx_r;
      assign vsrc = v7_r;
    end else begin : g_next
      assign src = sq_r[j-1];
      assign csrc = sqc_r[j-1];
      assign vsrc = sqv_r[j-1];
    end

    always_comb begin
      nx = src;
      for (int k = 0; k < SQ_PER; k++) begin
        if (j * SQ_PER + k < SQ_STEPS) begin
          nx = sq_step(nx);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[j] <= 1'b0;
      end else if (adv) begin
        sqv_r[j] <= vsrc;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j] <= nx;
        sqc_r[j] <= csrc;
      end
    end
  end

  // Stage T: t = x_t - l and the no-hit flag
  logic              vt_r;
  logic signed [38:0] st_t_r;
  logic              st_nohit_r;
  ctx_t              st_ctx_r;
  logic signed [38:0] tval;

  assign tval = 39'(sq_r[SQ_STG-1].xt) - $signed({8'b0, sq_r[SQ_STG-1].root});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (adv) begin
      vt_r <= sqv_r[SQ_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_t_r <= tval;
      st_nohit_r <= sq_r[SQ_STG-1].miss || tval[38];
      st_ctx_r <= sqc_r[SQ_STG-1];
    end
  end

  // Stage P: dir times t
  logic              vp_r;
  logic signed [54:0] sp_pp_r [3];
  logic              sp_nohit_r;
  ctx_t              sp_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sp_pp_r[i] <= $signed(st_ctx_r.dir[i]) * st_t_r;
      end
      sp_nohit_r <= st_nohit_r;
      sp_ctx_r <= st_ctx_r;
    end
  end

  // Output stage: hit point, saturate, select result
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         res;
  logic signed [54:0] ppr [3];
  logic signed [42:0] pt [3];
  logic [31:0]       pts [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ppr[i] = sp_pp_r[i] + 55'sd8192;
      pt[i] = 43'($signed(sp_ctx_r.org[i])) + 43'($signed(ppr[i][54:14]));
      pts[i] = sat32(pt[i]);
    end
    if (sp_ctx_r.org_in) begin
      res.hit = 1'b1;
      res.origin_inside = 1'b1;
      res.point_x = sp_ctx_r.org[0];
      res.point_y = sp_ctx_r.org[1];
      res.point_z = sp_ctx_r.org[2];
    end else if (sp_nohit_r) begin
      res = '0;
    end else begin
      res.hit = 1'b1;
      res.origin_inside = 1'b0;
      res.point_x = pts[0];
      res.point_y = pts[1];
      res.point_z = pts[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // Checks
  `RSHP_ASSERT_NOW(a_inside_is_hit, out_valid && out_data.origin_inside, out_data.hit)
  `RSHP_ASSERT_NOW(a_miss_zero_point, out_valid && !out_data.hit,
    out_data.point_x == 32'd0 && out_data.point_y == 32'd0 && out_data.point_z == 32'd0)
  `RSHP_ASSERT_NEXT(a_stall_holds_pipe, !in_ready, $stable(sqv_r) && $stable(vt_r))

endmodule

[bench/ray_sphere_hit_point_test.sv]
// Testbench for ray_sphere_hit_point: directed and random sphere/ray items,
// checked against an exact fixed-point hit point predictor. Depends on rshp_pkg.
`timescale 1ns / 100ps

module ray_sphere_hit_point_test;
  import rshp_pkg::*;

  // Expected hit results, oldest first
  class hit_scoreboard;
    out_item_t pending[$];
    int        errors;
    int        checked;
    int        hits;
    int        insides;

    // floor(v / 2^14 + 1/2)
    function automatic longint rnd14(longint v);
      return (v + 8192) >>> 14;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // Sum of squares; returns 0 when some component reaches 2^31
    function automatic bit sum_sq(longint a, longint b, longint c,
                                  output logic [63:0] s);
      longint v[3];
      logic [63:0] m;
      v[0] = a; v[1] = b; v[2] = c;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m = v[i] < 0 ? -v[i] : v[i];
        if (m >= 64'd2147483648) return 0;
        s = s + m * m;
      end
      return 1;
    endfunction

    // Note an accepted item and queue its expected result
    function void note_item(in_item_t it);
      longint c[3], o[3], dr[3], d[3], e[3];
      longint dot, xt, t;
      logic [63:0] r2, s;
      out_item_t res;
      c[0] = it.center_x; c[1] = it.center_y; c[2] = it.center_z;
      o[0] = it.origin_x; o[1] = it.origin_y; o[2] = it.origin_z;
      dr[0] = it.dir_x; dr[1] = it.dir_y; dr[2] = it.dir_z;
      for (int i = 0; i < 3; i++) d[i] = c[i] - o[i];
      r2 = 64'(it.sphere_radius) * 64'(it.sphere_radius);
      res = '0;
      if (sum_sq(d[0], d[1], d[2], s) && s < r2) begin
        res.hit = 1;
        res.origin_inside = 1;
        res.point_x = it.origin_x;
        res.point_y = it.origin_y;
        res.point_z = it.origin_z;
      end else begin
        dot = 0;
        for (int i = 0; i < 3; i++) dot += d[i] * dr[i];
        xt = rnd14(dot);
        for (int i = 0; i < 3; i++) e[i] = rnd14(dr[i] * xt) - d[i];
        if (sum_sq(e[0], e[1], e[2], s) && s <= r2) begin
          t = xt - longint'(isqrt(r2 - s));
          if (t >= 0) begin
            res.hit = 1;
            res.point_x = clamp32(o[0] + rnd14(dr[0] * t));
            res.point_y = clamp32(o[1] + rnd14(dr[1] * t));
            res.point_z = clamp32(o[2] + rnd14(dr[2] * t));
          end
        end
      end
      pending.push_back(res);
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.hit) hits++;
      if (want.origin_inside) insides++;
      if (got.hit !== want.hit)
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
      if (got.origin_inside !== want.origin_inside)
        $display("%0t: origin_inside expected %0d actual %0d", $time,
                 want.origin_inside, got.origin_inside);
      if (got.point_x !== want.point_x)
        $display("%0t: point_x expected %h actual %h", $time, want.point_x, got.point_x);
      if (got.point_y !== want.point_y)
        $display("%0t: point_y expected %h actual %h", $time, want.point_y, got.point_y);
      if (got.point_z !== want.point_z)
        $display("%0t: point_z expected %h actual %h", $time, want.point_z, got.point_z);
      if (got !== want) errors++;
    endfunction
  endclass

  localparam int LATENCY   = 26;
  localparam int N_RANDOM  = 1080;
  localparam int CYCLE_CAP = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  hit_scoreboard sb;
  bit  quiet;        // no idling in the last part of the run
  bit  long_hold;    // receiver holds off for a long stretch
  int  cycles;

  ray_sphere_hit_point u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Note accepted items and check accepted results at each edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_item(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL ray_sphere_hit_point");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(in_item_t it);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  // Roughly unit direction, sometimes arbitrary bits
  function automatic void rand_dir(ref in_item_t it);
    if ($urandom_range(0, 6) == 0) begin
      it.dir_x = 16'($urandom); it.dir_y = 16'($urandom); it.dir_z = 16'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0: begin it.dir_x = 16'sd16384; it.dir_y = 0; it.dir_z = 0; end
        1: begin it.dir_x = 16'sd9459; it.dir_y = 16'sd9459; it.dir_z = 16'sd9459; end
        default: begin it.dir_x = 16'sd11585; it.dir_y = 16'sd11585; it.dir_z = 0; end
      endcase
      if ($urandom_range(0, 1)) it.dir_x = -it.dir_x;
      if ($urandom_range(0, 1)) it.dir_y = -it.dir_y;
      if ($urandom_range(0, 1)) it.dir_z = -it.dir_z;
      if ($urandom_range(0, 1)) {it.dir_x, it.dir_y} = {it.dir_y, it.dir_x};
      if ($urandom_range(0, 1)) {it.dir_y, it.dir_z} = {it.dir_z, it.dir_y};
    end
  endfunction

  // Mostly rays aimed near the sphere so hits are common
  function automatic in_item_t rand_item();
    in_item_t it;
    int mode;
    mode = $urandom_range(0, 9);
    it.center_x = rand_coord(); it.center_y = rand_coord(); it.center_z = rand_coord();
    it.sphere_radius = $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                  : 31'($urandom_range(0, 8000000));
    it.origin_x = rand_coord(); it.origin_y = rand_coord(); it.origin_z = rand_coord();
    rand_dir(it);
    if (mode < 6) begin
      // aim toward the center with a small offset
      it.origin_x = it.center_x - 32'(it.dir_x * $urandom_range(0, 600));
      it.origin_y = it.center_y - 32'(it.dir_y * $urandom_range(0, 600))
                    + 32'($signed($urandom_range(0, 4000000)) - 2000000);
      it.origin_z = it.center_z - 32'(it.dir_z * $urandom_range(0, 600));
    end else if (mode < 8) begin
      // start near the center
      it.origin_x = it.center_x + 32'($signed($urandom_range(0, 2000)) - 1000);
      it.origin_y = it.center_y + 32'($signed($urandom_range(0, 2000)) - 1000);
      it.origin_z = it.center_z;
    end
    return it;
  endfunction

  function automatic in_item_t make_item(logic [31:0] cx, logic [31:0] cy,
      logic [31:0] cz, logic [30:0] r, logic [31:0] ox, logic [31:0] oy,
      logic [31:0] oz, logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    in_item_t it;
    it.center_x = cx; it.center_y = cy; it.center_z = cz; it.sphere_radius = r;
    it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
    it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
    return it;
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t directed[$];
    in_item_t it;
    sb = new();
    cycles = 0;
    quiet = 0;
    long_hold = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: hit ahead, origin inside, on surface, tangent, miss, behind,
    // far sphere, saturation, zero radius, odd direction bits, hits along z and y
    directed.push_back(make_item(32'sd10 << 16, 0, 0, 31'd2 << 16, 0, 0, 0,
                                 16'sd16384, 0, 0));
    directed.push_back(make_item(0, 0, 0, 31'd5 << 16, 32'sd1 << 16, 0, 0,
                                 16'sd16384, 0, 0));
    directed.push_back(make_item(0, 0, 0, 31'd5 << 16, 32'sd5 << 16, 0, 0,
                                 -16'sd16384, 0, 0));
    directed.push_back(make_item(32'sd10 << 16, 32'sd3 << 16, 0, 31'd3 << 16, 0, 0, 0,
                                 16'sd16384, 0, 0));
    directed.push_back(make_item(32'sd10 << 16, 32'sd9 << 16, 0, 31'd3 << 16, 0, 0, 0,
                                 16'sd16384, 0, 0));
    directed.push_back(make_item(-32'sd10 << 16, 0, 0, 31'd2 << 16, 0, 0, 0,
                                 16'sd16384, 0, 0));
    directed.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 16'sd9459, 16'sd9459, 16'sd9459));
    directed.push_back(make_item(32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF,
                                 32'h8000_0000, 0, 0, 16'sd16384, 0, 0));
    directed.push_back(make_item(32'h7000_0000, 0, 0, 31'h7FFF_FFFF,
                                 32'h8000_0000, 0, 0, -16'sd16384, 0, 0));
    directed.push_back(make_item(32'h7FFF_0000, 0, 0, 31'h0100_0000,
                                 32'h7000_0000, 0, 0, 16'sd16384, 0, 0));
    directed.push_back(make_item(0, 0, 0, 31'd0, 0, 0, 0, 16'sd16384, 0, 0));
    directed.push_back(make_item(32'sd4 << 16, 0, 0, 31'd0, 0, 0, 0, 16'sd16384, 0, 0));
    directed.push_back(make_item(32'sd100 << 16, 0, 0, 31'd10 << 16, 0, 0, 0,
                                 16'h7FFF, 16'h8000, 16'hFFFF));
    directed.push_back(make_item(32'sd100 << 16, 32'sd100 << 16, 32'sd100 << 16,
                                 31'd20 << 16, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000));
    directed.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 16'h7FFF, 16'h7FFF, 16'h7FFF));
    directed.push_back(make_item(0, 0, 32'sd50 << 16, 31'd3 << 16, 0, 0, 0,
                                 0, 0, 16'sd16384));
    directed.push_back(make_item(0, 32'sd50 << 16, 0, 31'd3 << 16, 0, 0, 0,
                                 0, 16'sd16384, 0));
    foreach (directed[i]) send_item(directed[i]);
    drop_valid();

    // Sender pause until everything is back
    wait_drained();

    // Receiver long hold-off while items keep coming
    long_hold = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) quiet = 1;
      it = rand_item();
      send_item(it);
    end
    drop_valid();

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results: %0d hits, %0d with origin inside.",
             sb.checked, sb.hits, sb.insides);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS ray_sphere_hit_point");
    end else begin
      $display("FAIL ray_sphere_hit_point");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/rshp_pkg.sv
sv/ray_sphere_hit_point.sv
bench/ray_sphere_hit_point_test.sv
